### rtl/core/dasp_pkg.sv
package dasp_pkg;

   localparam int OffW = 63;
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_RANGE = 3'd1;
   localparam logic [2:0] KIND_TABLE_END = 3'd2;
   localparam logic [2:0] KIND_TRUNC = 3'd3;
   localparam logic [2:0] KIND_BAD_SEG = 3'd4;
   localparam logic [2:0] KIND_BAD_ADDR = 3'd5;
   localparam logic [2:0] KIND_OVERFLOW = 3'd6;
   localparam logic [2:0] KIND_ZERO_ALIGN = 3'd7;
   localparam logic [63:0] MAX63 = 64'h7fff_ffff_ffff_ffff;
   localparam int QueueDepth = 2;

   typedef struct packed {
      logic       eos;
      logic [7:0] data;
   } word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] c;
      logic [62:0] fol;
      logic [15:0] ver;
      logic [7:0]  asz;
      logic [7:0]  ssz;
      logic        wide;
      logic [62:0] ustart;
      logic        last;
   } rsp_type;

endpackage

### rtl/core/dasp_front.sv
module dasp_front
   import dasp_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  word_type req_word,
   output logic     q_valid,
   input  logic     q_take,
   output word_type q_word
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW = $clog2(Depth + 1);
   word_type mem [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == CW'(Depth));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_take;
   assign q_word = mem[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      if (push) wp_in = (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
      if (pop) rp_in = (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wp_ff] <= req_word;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### rtl/core/dasp_back.sv
module dasp_back
   import dasp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   output logic     q_take,
   input  word_type q_word,
   output logic     out_valid,
   input  logic     out_stall,
   output rsp_type  out_rsp
);
   localparam logic [3:0] PH_LEN32 = 4'd0, PH_LEN64 = 4'd1, PH_VER = 4'd2, PH_INFO = 4'd3,
      PH_ASZ = 4'd4, PH_SSZ = 4'd5, PH_PAD = 4'd6, PH_SEG = 4'd7, PH_ADDR = 4'd8,
      PH_RLEN = 4'd9, PH_SKIP = 4'd10, PH_HALT = 4'd11, PH_CHK = 4'd12, PH_MOD = 4'd13,
      PH_FIN = 4'd14;

   logic [3:0]  ph_ff, ph_in;
   logic [62:0] pos_ff, pos_in;
   logic [63:0] sh_ff, sh_in;
   logic [3:0]  bc_ff, bc_in;
   logic        wide_ff, wide_in;
   logic [63:0] len_ff, len_in, info_ff, info_in, seg_ff, seg_in, adr_ff, adr_in;
   logic [15:0] ver_ff, ver_in;
   logic [7:0]  asz_ff, asz_in, ssz_ff, ssz_in;
   logic [62:0] hs_ff, hs_in, ts_ff, ts_in, nu_ff, nu_in;
   // header check scratch: t, remainder division
   logic [63:0] t_ff, t_in, rem_ff, rem_in;
   logic [6:0]  it_ff, it_in;
   logic [2:0]  err_ff, err_in;
   logic        errv_ff, errv_in;
   // two-entry result buffer
   rsp_type     r0_ff, r0_in, r1_ff, r1_in;
   logic [1:0]  rn_ff, rn_in;

   logic [62:0] npos;
   logic [63:0] acc, need, al;
   logic [3:0]  bcn;
   logic        done, busy, tk;

   assign npos = pos_ff + 63'd1;
   assign al = {56'd0, ssz_ff} + {55'd0, asz_ff, 1'b0};
   assign busy = (ph_ff == PH_CHK) || (ph_ff == PH_MOD) || (ph_ff == PH_FIN);
   assign q_take = q_valid && rn_ff == 2'd0 && !busy;
   assign tk = q_take;
   assign out_valid = rn_ff != 2'd0;
   assign out_rsp = r0_ff;

   always_comb begin
      acc = sh_ff | ({56'd0, q_word.data} << {bc_ff[2:0], 3'b000});
      bcn = bc_ff + 4'd1;
      need = 64'd0;
      unique case (ph_ff)
         PH_LEN32: need = 64'd4;
         PH_LEN64: need = 64'd8;
         PH_VER: need = 64'd2;
         PH_INFO: need = wide_ff ? 64'd8 : 64'd4;
         PH_SEG: need = {56'd0, ssz_ff};
         PH_ADDR, PH_RLEN: need = {56'd0, asz_ff};
         default: need = 64'd0;
      endcase
      done = {60'd0, bcn} >= need;
   end

   function automatic rsp_type mk(input logic [2:0] k, input logic [63:0] a, b, c,
         input logic [62:0] nu, input logic [15:0] v, input logic [7:0] az, sz,
         input logic w, input logic [62:0] hs, input logic l);
      rsp_type r;
      r.kind = k; r.a = a; r.b = b; r.c = c; r.fol = nu; r.ver = v; r.asz = az;
      r.ssz = sz; r.wide = w; r.ustart = hs; r.last = l;
      return r;
   endfunction

   always_comb begin
      logic [63:0] hl, ll, tot, d, tn;
      ph_in = ph_ff; pos_in = pos_ff; sh_in = sh_ff; bc_in = bc_ff; wide_in = wide_ff;
      len_in = len_ff; info_in = info_ff; seg_in = seg_ff; adr_in = adr_ff;
      ver_in = ver_ff; asz_in = asz_ff; ssz_in = ssz_ff; hs_in = hs_ff; ts_in = ts_ff;
      nu_in = nu_ff; t_in = t_ff; rem_in = rem_ff; it_in = it_ff; err_in = err_ff;
      errv_in = errv_ff; r0_in = r0_ff; r1_in = r1_ff; rn_in = rn_ff;
      hl = wide_ff ? 64'd24 : 64'd12;
      ll = wide_ff ? 64'd12 : 64'd4;
      tot = len_ff + ll;
      d = {rem_ff[62:0], t_ff[6'(63 - it_ff[5:0])]};
      tn = t_ff;
      if (out_valid && !out_stall) begin
         r0_in = r1_ff;
         rn_in = rn_ff - 2'd1;
      end
      if (tk) begin
         if (q_word.eos) begin
            if ((ph_ff == PH_LEN32 && bc_ff != 0) ||
                (ph_ff >= PH_LEN64 && ph_ff <= PH_RLEN)) begin
               r0_in = mk(KIND_TRUNC, 0, 0, 0, nu_ff, ver_ff, asz_ff, ssz_ff, wide_ff,
                  hs_ff, 1'b1);
               rn_in = 2'd1;
            end
            ph_in = PH_HALT; sh_in = '0; bc_in = '0;
         end else begin
            pos_in = npos;
            unique case (ph_ff)
               PH_LEN32, PH_LEN64, PH_VER, PH_INFO, PH_SEG, PH_ADDR, PH_RLEN: begin
                  if (ph_ff == PH_LEN32 && bc_ff == 0) begin
                     hs_in = pos_ff; wide_in = 0; len_in = 0; ver_in = 0; info_in = 0;
                     asz_in = 0; ssz_in = 0; ts_in = 0; nu_in = 0;
                  end
                  if (ph_ff == PH_ADDR && bc_ff == 0 && ssz_ff == 0) seg_in = 0;
                  sh_in = acc; bc_in = bcn;
                  if (done) begin
                     sh_in = '0; bc_in = '0;
                     unique case (ph_ff)
                        PH_LEN32: if (acc == 64'hffff_ffff) begin
                              wide_in = 1; ph_in = PH_LEN64;
                           end else begin
                              len_in = acc; ph_in = PH_VER;
                           end
                        PH_LEN64: begin len_in = acc; ph_in = PH_VER; end
                        PH_VER: begin ver_in = acc[15:0]; ph_in = PH_INFO; end
                        PH_INFO: begin info_in = acc; ph_in = PH_ASZ; end
                        PH_SEG: begin seg_in = acc; ph_in = PH_ADDR; end
                        PH_ADDR: begin adr_in = acc; ph_in = PH_RLEN; end
                        default: begin
                           if (seg_ff == 0 && adr_ff == 0 && acc == 0) begin
                              r0_in = mk(KIND_TABLE_END, 0, 0, 0, nu_ff, ver_ff, asz_ff,
                                 ssz_ff, wide_ff, hs_ff, 1'b1);
                              ph_in = (npos < nu_ff) ? PH_SKIP : PH_LEN32;
                           end else begin
                              r0_in = mk(KIND_RANGE, seg_ff, adr_ff, acc, nu_ff, ver_ff,
                                 asz_ff, ssz_ff, wide_ff, hs_ff, 1'b1);
                              ph_in = (ssz_ff == 0) ? PH_ADDR : PH_SEG;
                           end
                           rn_in = 2'd1;
                        end
                     endcase
                  end
               end
               PH_ASZ: begin asz_in = q_word.data; ph_in = PH_SSZ; end
               PH_SSZ: begin ssz_in = q_word.data; ph_in = PH_CHK; end
               PH_PAD: if (npos >= ts_ff) ph_in = (ssz_ff == 0) ? PH_ADDR : PH_SEG;
               PH_SKIP: if (npos >= nu_ff) ph_in = PH_LEN32;
               default: ph_in = PH_HALT;
            endcase
         end
      end else begin
         unique case (ph_ff)
            PH_CHK: begin
               ts_in = '0; nu_in = '0; errv_in = 0;
               if ({1'b0, hs_ff} > MAX63 - hl) begin
                  errv_in = 1; err_in = KIND_OVERFLOW; ph_in = PH_FIN;
               end else if (al == 0) begin
                  errv_in = 1; err_in = KIND_ZERO_ALIGN; ph_in = PH_FIN;
               end else begin
                  t_in = {1'b0, hs_ff} + hl; rem_in = '0; it_in = '0; ph_in = PH_MOD;
               end
            end
            PH_MOD: begin
               // restoring remainder, one bit per cycle
               rem_in = (d >= al) ? d - al : d;
               it_in = it_ff + 7'd1;
               if (it_ff == 7'd63) begin
                  ph_in = PH_FIN;
                  if (rem_in != 0) begin
                     if (t_ff > MAX63 - (al - rem_in)) begin
                        errv_in = 1; err_in = KIND_OVERFLOW;
                     end else tn = t_ff + (al - rem_in);
                  end
                  t_in = tn;
                  if (!errv_in) ts_in = tn[62:0];
               end
            end
            PH_FIN: if (rn_ff == 0) begin
               if (!errv_ff) begin
                  if (tot < ll || tot > MAX63 || {1'b0, hs_ff} > MAX63 - tot) begin
                     errv_in = 1; err_in = KIND_OVERFLOW;
                  end else nu_in = hs_ff + tot[62:0];
                  if (!errv_in && ssz_ff != 0 && ssz_ff != 4 && ssz_ff != 8) begin
                     errv_in = 1; err_in = KIND_BAD_SEG;
                  end
                  if (!errv_in && asz_ff != 4 && asz_ff != 8) begin
                     errv_in = 1; err_in = KIND_BAD_ADDR;
                  end
               end
               r0_in = mk(KIND_HEADER, len_ff, info_ff, {1'b0, ts_ff}, nu_in, ver_ff,
                  asz_ff, ssz_ff, wide_ff, hs_ff, !errv_in);
               r1_in = mk(err_in, 0, 0, 0, nu_in, ver_ff, asz_ff, ssz_ff, wide_ff,
                  hs_ff, 1'b1);
               if (errv_in) begin
                  rn_in = 2'd2; ph_in = PH_HALT;
               end else begin
                  rn_in = 2'd1;
                  ph_in = (pos_ff < ts_ff) ? PH_PAD : ((ssz_ff == 0) ? PH_ADDR : PH_SEG);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; rem_ff <= rem_in; it_ff <= it_in; err_ff <= err_in;
      errv_ff <= errv_in; r0_ff <= r0_in; r1_ff <= r1_in;
      if (reset) begin
         ph_ff <= PH_LEN32; pos_ff <= '0; bc_ff <= '0; rn_ff <= '0;
         sh_ff <= '0; wide_ff <= 0; len_ff <= '0; ver_ff <= '0; info_ff <= '0;
         asz_ff <= '0; ssz_ff <= '0; hs_ff <= '0; ts_ff <= '0; nu_ff <= '0;
         seg_ff <= '0; adr_ff <= '0;
      end else begin
         ph_ff <= ph_in; pos_ff <= pos_in; bc_ff <= bc_in; rn_ff <= rn_in;
         sh_ff <= sh_in; wide_ff <= wide_in; len_ff <= len_in; ver_ff <= ver_in;
         info_ff <= info_in; asz_ff <= asz_in; ssz_ff <= ssz_in; hs_ff <= hs_in;
         ts_ff <= ts_in; nu_ff <= nu_in; seg_ff <= seg_in; adr_ff <= adr_in;
      end
   end
endmodule

### rtl/core/dwarf_aranges_stream_parser_core.sv
// Path: a word passes the queue stage and then the parse stage before its result is valid.
// Throughput: one word per cycle while no result is held; a header end stops intake for the
// header check and its bit-serial table-offset remainder (skipped when the check fails before
// the remainder), and each result is held until taken before the next word is parsed.
// Reset (synchronous, active high) clears the queue, the parse state and all offsets.
module dwarf_aranges_stream_parser_core
   import dasp_pkg::*;
#(
   parameter int Depth = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_section_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [63:0] rsp_value_a,
   output logic [63:0] rsp_value_b,
   output logic [63:0] rsp_value_c,
   output logic [62:0] rsp_following_offset,
   output logic [15:0] rsp_format_version,
   output logic [7:0]  rsp_addr_bytes,
   output logic [7:0]  rsp_seg_bytes,
   output logic        rsp_wide_format,
   output logic [62:0] rsp_unit_start,
   output logic        rsp_last
);
   word_type w, qw;
   logic qv, qt;
   rsp_type r;

   assign w.data = req_data_byte;
   assign w.eos = req_section_end;

   dasp_front #(.Depth(Depth)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word(w),
      .q_valid(qv), .q_take(qt), .q_word(qw)
   );

   dasp_back u_back (
      .clock, .reset, .q_valid(qv), .q_take(qt), .q_word(qw),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_rsp(r)
   );

   assign rsp_kind = r.kind;
   assign rsp_value_a = r.a;
   assign rsp_value_b = r.b;
   assign rsp_value_c = r.c;
   assign rsp_following_offset = r.fol;
   assign rsp_format_version = r.ver;
   assign rsp_addr_bytes = r.asz;
   assign rsp_seg_bytes = r.ssz;
   assign rsp_wide_format = r.wide;
   assign rsp_unit_start = r.ustart;
   assign rsp_last = r.last;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind))
      else $error("result changed while stalled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> !(qv && qt) || rsp_valid)
      else $error("word consumed while result blocked");
endmodule
